FILE: hw/rtl/hsoc_pkg.sv
// hsoc_pkg: shared widths, datapath command codes and the saturating counter add
// for the heap sort engine; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package hsoc_pkg;

  localparam int VALUE_W          = 32;
  localparam int INDEX_W          = 10;
  localparam int COUNT_W          = 24;
  localparam int DEF_MAX_ELEMENTS = 1024;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // datapath commands, one per cycle from the controller
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_READ   = 5'd2;
  localparam logic [OP_W-1:0] OP_OUT    = 5'd3;
  localparam logic [OP_W-1:0] OP_INIT   = 5'd4;
  localparam logic [OP_W-1:0] OP_SSTART = 5'd5;
  localparam logic [OP_W-1:0] OP_SHELD  = 5'd6;
  localparam logic [OP_W-1:0] OP_CHILD  = 5'd7;
  localparam logic [OP_W-1:0] OP_RDA    = 5'd8;
  localparam logic [OP_W-1:0] OP_RDB    = 5'd9;
  localparam logic [OP_W-1:0] OP_CMP    = 5'd10;
  localparam logic [OP_W-1:0] OP_SEND_B = 5'd11;
  localparam logic [OP_W-1:0] OP_SEND_X = 5'd12;
  localparam logic [OP_W-1:0] OP_XSTART = 5'd13;
  localparam logic [OP_W-1:0] OP_SWA    = 5'd14;
  localparam logic [OP_W-1:0] OP_SWB    = 5'd15;
  localparam logic [OP_W-1:0] OP_SWC    = 5'd16;
  localparam logic [OP_W-1:0] OP_SWD    = 5'd17;
  localparam logic [OP_W-1:0] OP_DONE   = 5'd18;

  typedef struct packed {
    logic child_gt;   // first child of pos lies past the bound
    logic child_lt;   // first child has a right sibling inside the bound
    logic b_less;     // right sibling smaller than left child
    logic c_less;     // chosen child smaller than the held value
    logic top_zero;
    logic ext_one;
    logic n_zero;
    logic n_lt2;
    logic out_busy;   // result waits and downstream stalls
  } dp_status_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [1:0] inc);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {{(COUNT_W - 1){1'b0}}, inc};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/hsoc_ctrl.sv
// hsoc_ctrl: sequencing state machine of the heap sort engine
// depends on hsoc_pkg for command codes and the status struct
`timescale 1ns / 1ps

module hsoc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    cmd,
  input  logic                    last,
  input  hsoc_pkg::dp_status_t    status,
  output logic                    in_stall,
  output logic [hsoc_pkg::OP_W-1:0] op
);
  import hsoc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDW    = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_SSTART = 4'd3;
  localparam logic [3:0] S_SHELD  = 4'd4;
  localparam logic [3:0] S_CHILD  = 4'd5;
  localparam logic [3:0] S_RDA    = 4'd6;
  localparam logic [3:0] S_RDB    = 4'd7;
  localparam logic [3:0] S_CMP    = 4'd8;
  localparam logic [3:0] S_SEND   = 4'd9;
  localparam logic [3:0] S_XSTART = 4'd10;
  localparam logic [3:0] S_SWA    = 4'd11;
  localparam logic [3:0] S_SWB    = 4'd12;
  localparam logic [3:0] S_SWC    = 4'd13;
  localparam logic [3:0] S_SWD    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0] state, state_next;
  logic       extract, extract_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    extract_next = extract;
    op           = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd) begin
            op         = OP_READ;
            state_next = S_RDW;
          end else begin
            op = OP_LOAD;
            if (last) state_next = S_INIT;
          end
        end
      end
      S_RDW: begin
        if (!status.out_busy) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      S_INIT: begin
        op           = OP_INIT;
        extract_next = 1'b0;
        state_next   = status.n_zero ? S_DONE : S_SSTART;
      end
      S_SSTART: begin
        op         = OP_SSTART;
        state_next = S_SHELD;
      end
      S_SHELD: begin
        op         = OP_SHELD;
        state_next = S_CHILD;
      end
      S_CHILD: begin
        op         = OP_CHILD;
        state_next = status.child_gt ? S_SEND : S_RDA;
      end
      S_RDA: begin
        op         = OP_RDA;
        state_next = status.child_lt ? S_RDB : S_CMP;
      end
      S_RDB: begin
        op         = OP_RDB;
        state_next = S_CMP;
      end
      S_CMP: begin
        op         = OP_CMP;
        state_next = status.c_less ? S_CHILD : S_SEND;
      end
      S_SEND: begin
        if (extract) begin
          op         = OP_SEND_X;
          state_next = status.ext_one ? S_DONE : S_SWA;
        end else begin
          op = OP_SEND_B;
          if (!status.top_zero) state_next = S_SSTART;
          else state_next = status.n_lt2 ? S_DONE : S_XSTART;
        end
      end
      S_XSTART: begin
        op           = OP_XSTART;
        extract_next = 1'b1;
        state_next   = S_SWA;
      end
      S_SWA: begin
        op         = OP_SWA;
        state_next = S_SWB;
      end
      S_SWB: begin
        op         = OP_SWB;
        state_next = S_SWC;
      end
      S_SWC: begin
        op         = OP_SWC;
        state_next = S_SWD;
      end
      S_SWD: begin
        op         = OP_SWD;
        state_next = S_SSTART;
      end
      S_DONE: begin
        op         = OP_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      extract <= 1'b0;
    end else begin
      state   <= state_next;
      extract <= extract_next;
    end
  end

  // a sort starts only from an accepted load marked last
  a_sort_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && (state_next == S_INIT) |-> in_valid && !cmd && last)
    else $error("sort started without a last load");

endmodule

FILE: hw/rtl/hsoc_dp.sv
// hsoc_dp: element memory, sift registers, operation counter and result register
// depends on hsoc_pkg; driven by hsoc_ctrl commands
`timescale 1ns / 1ps

module hsoc_dp #(
  parameter int MAX_ELEMENTS = hsoc_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hsoc_pkg::OP_W-1:0]            op,
  input  logic signed [hsoc_pkg::VALUE_W-1:0]  value,
  input  logic [hsoc_pkg::INDEX_W-1:0]         index,
  input  logic                                 out_stall,
  output hsoc_pkg::dp_status_t                 status,
  output logic                                 out_valid,
  output logic signed [hsoc_pkg::VALUE_W-1:0]  sorted_value,
  output logic [hsoc_pkg::COUNT_W-1:0]         op_count
);
  import hsoc_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  logic [VALUE_W-1:0] mem [MAX_ELEMENTS];

  logic [CW-1:0]      count;
  logic               sort_done;
  logic [COUNT_W-1:0] total;
  logic [AW-1:0]      top, sb, ext, pos;
  logic [AW:0]        child;
  logic [VALUE_W-1:0] held, cval, rdata;
  logic               in_range;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [AW:0]        pos2, child_p1;
  logic [CW-1:0]      cnt_m1, cnt_half;
  logic [31:0]        idx32;
  logic               not_full;

  assign pos2     = {pos, 1'b0};
  assign child_p1 = child + (AW + 1)'(1);
  assign cnt_m1   = count - CW'(1);
  assign cnt_half = count >> 1;
  assign idx32    = 32'(index);
  assign not_full = (count < MAX_CNT);

  assign status.child_gt = (pos2 > {1'b0, sb});
  assign status.child_lt = (child < {1'b0, sb});
  assign status.b_less   = ($signed(rdata) < $signed(cval));
  assign status.c_less   = ($signed(cval) < $signed(held));
  assign status.top_zero = (top == '0);
  assign status.ext_one  = (ext == AW'(1));
  assign status.n_zero   = (count == '0);
  assign status.n_lt2    = (count < CW'(2));
  assign status.out_busy = out_valid && out_stall;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = held;
    case (op)
      OP_READ: begin
        rd_en   = 1'b1;
        rd_addr = idx32[AW-1:0];
      end
      OP_LOAD: begin
        wr_data = value;
        if (sort_done) begin
          wr_en = 1'b1;
        end else if (not_full) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
        end
      end
      OP_SSTART: begin
        rd_en   = 1'b1;
        rd_addr = top;
      end
      OP_CHILD: begin
        rd_en   = !status.child_gt;
        rd_addr = pos2[AW-1:0];
      end
      OP_RDA: begin
        rd_en   = status.child_lt;
        rd_addr = child_p1[AW-1:0];
      end
      OP_CMP: begin
        wr_en   = status.c_less;
        wr_addr = pos;
        wr_data = cval;
      end
      OP_SEND_B, OP_SEND_X: begin
        wr_en   = 1'b1;
        wr_addr = pos;
      end
      OP_SWA: begin
        rd_en = 1'b1;
      end
      OP_SWB: begin
        rd_en   = 1'b1;
        rd_addr = ext;
      end
      OP_SWC: begin
        wr_en   = 1'b1;
        wr_data = rdata;
      end
      OP_SWD: begin
        wr_en   = 1'b1;
        wr_addr = ext;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // sift registers, no reset needed
  always_ff @(posedge clk) begin
    case (op)
      OP_READ:   in_range <= (idx32 < 32'(count));
      OP_INIT: begin
        top <= cnt_half[AW-1:0];
        sb  <= cnt_m1[AW-1:0];
      end
      OP_SSTART: pos <= top;
      OP_SHELD:  held <= rdata;
      OP_CHILD:  child <= pos2;
      OP_RDA:    cval <= rdata;
      OP_RDB: begin
        if (status.b_less) begin
          cval  <= rdata;
          child <= child_p1;
        end
      end
      OP_CMP:    if (status.c_less) pos <= child[AW-1:0];
      OP_SEND_B: if (!status.top_zero) top <= top - AW'(1);
      OP_SEND_X: if (!status.ext_one) ext <= ext - AW'(1);
      OP_XSTART: ext <= cnt_m1[AW-1:0];
      OP_SWB:    held <= rdata;
      OP_SWD: begin
        top <= '0;
        sb  <= ext - AW'(1);
      end
      default: begin
      end
    endcase
    if (op == OP_OUT) begin
      sorted_value <= in_range ? rdata : '0;
      op_count     <= total;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sort_done <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          if (sort_done) begin
            count     <= CW'(1);
            sort_done <= 1'b0;
          end else if (not_full) begin
            count <= count + CW'(1);
          end
        end
        OP_INIT:   total <= status.n_zero ? COUNT_W'(2) : '0;
        OP_SSTART: total <= sat_add(total, 2'd2);
        OP_CHILD:  if (!status.child_gt) total <= sat_add(total, 2'd1);
        OP_CMP:    total <= sat_add(total, status.c_less ? 2'd2 : 2'd1);
        OP_SWD:    total <= sat_add(total, 2'd3);
        OP_DONE:   sort_done <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("element count past capacity");

  a_sort_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && (op != OP_LOAD) |-> 32'(wr_addr) < 32'(count))
    else $error("sort wrote outside the loaded slots");

  a_sort_read: assert property (@(posedge clk) disable iff (rst)
    rd_en && (op != OP_READ) |-> 32'(rd_addr) < 32'(count))
    else $error("sort read outside the loaded slots");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (op != OP_INIT) |=> total >= $past(total))
    else $error("operation count went down inside a sort");

endmodule

FILE: hw/rtl/heap_sort_with_op_count_core.sv
// heap_sort_with_op_count_core: top level of the heap sort engine with operation count
// instantiates hsoc_ctrl and hsoc_dp; depends on hsoc_pkg
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  cmd, value, last, index
// out      from block out_valid / out_stall sorted_value, op_count
//
// a load is one memory write, made as it is accepted; a read goes through the
// memory read register, then the result register, and waits while the result
// register is still held by out_stall
// a last load starts the sort: heap build then extraction through the element
// memory, one read or write a cycle; a sift level walks the child, read A,
// optional read B and compare states, and in_stall is high for the whole sort
// rst is synchronous: count, sort flag, operation total and result valid clear;
// the element memory holds no reset; a read outside the loaded slots gives zero
// a waiting result does not block loads; the next read waits for it to drain
`timescale 1ns / 1ps

module heap_sort_with_op_count_core #(
  parameter int MAX_ELEMENTS = hsoc_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [hsoc_pkg::VALUE_W-1:0]  value,
  input  logic                                 last,
  input  logic [hsoc_pkg::INDEX_W-1:0]         index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [hsoc_pkg::VALUE_W-1:0]  sorted_value,
  output logic [hsoc_pkg::COUNT_W-1:0]         op_count
);
  import hsoc_pkg::*;

  // command and status between the sequencer and the datapath
  logic [OP_W-1:0] op;
  dp_status_t      status;

  // state machine: accepts items in idle, walks the sift/swap sequence
  hsoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .last     (last),
    .status   (status),
    .in_stall (in_stall),
    .op       (op)
  );

  // memory, heap pointers, saturating op counter and result register
  hsoc_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .value        (value),
    .index        (index),
    .out_stall    (out_stall),
    .status       (status),
    .out_valid    (out_valid),
    .sorted_value (sorted_value),
    .op_count     (op_count)
  );

endmodule

FILE: tb/testbench.sv
// testbench for heap_sort_with_op_count_core: loads sets of signed values, reads them back
// after the in-place sort and checks each result against a cycle-free shadow of the sorter
// depends on hsoc_pkg and the core rtl only
`timescale 1ns / 1ps

module testbench;
  import hsoc_pkg::*;

  localparam int MAX_ELEMENTS = DEF_MAX_ELEMENTS;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 210;

  // item commands on the input channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // one read result: element and operation total
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        ops;
  } readout_t;

  localparam readout_t NO_WANT = '0;

  // directed row: item fields, plus a hand-written result where one is obvious
  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic [INDEX_W-1:0]        index;
    logic                      typed;
    readout_t                  want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // nothing loaded yet: out of range reads give zero with a zero count
    '{CMD_READ, 32'sd0, 1'b0, 10'd0, 1'b1, NO_WANT},
    '{CMD_READ, -32'sd1, 1'b1, 10'd1023, 1'b1, NO_WANT},
    // a set built from the extremes of the value field
    '{CMD_LOAD, 32'sh7fffffff, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_LOAD, 32'sh80000000, 1'b0, 10'd512, 1'b0, NO_WANT},
    '{CMD_LOAD, 32'sd0, 1'b0, 10'd1023, 1'b0, NO_WANT},
    // read before the sort sees the element as loaded
    '{CMD_READ, 32'sd0, 1'b0, 10'd1, 1'b1, '{32'sh80000000, 24'd0}},
    '{CMD_LOAD, -32'sd1, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_LOAD, 32'sd1, 1'b1, 10'd0, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd1, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd2, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd3, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd4, 1'b0, NO_WANT},
    // one past the end of the set
    '{CMD_READ, 32'sd0, 1'b0, 10'd5, 1'b0, NO_WANT},
    // load after a sort starts a new set, here a set of one
    '{CMD_LOAD, 32'sd42, 1'b1, 10'd0, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd0, 1'b0, NO_WANT},
    // duplicates in a small set
    '{CMD_LOAD, 32'sd5, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_LOAD, 32'sd5, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_LOAD, -32'sd5, 1'b1, 10'd0, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd2, 1'b0, NO_WANT},
    // two equal minimum values
    '{CMD_LOAD, 32'sh80000000, 1'b0, 10'd0, 1'b0, NO_WANT},
    '{CMD_LOAD, 32'sh80000000, 1'b1, 10'd0, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd1, 1'b0, NO_WANT},
    '{CMD_READ, 32'sd0, 1'b0, 10'd1023, 1'b0, NO_WANT}
  };

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // dut ports, with the inputs driven to known values from time zero
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      cmd = CMD_LOAD;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      last = 1'b0;
  logic [INDEX_W-1:0]        index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] sorted_value;
  logic [COUNT_W-1:0]        op_count;

  heap_sort_with_op_count_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .value(value),
    .last(last),
    .index(index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sorted_value(sorted_value),
    .op_count(op_count)
  );

  // shadow copy of the sorter state, updated once per accepted item
  logic signed [VALUE_W-1:0] shadow_mem [MAX_ELEMENTS];
  int unsigned               shadow_count = 0;
  logic [COUNT_W-1:0]        shadow_ops = '0;
  bit                        shadow_sorted = 1'b0;

  // reads accepted whose results have not come out yet, oldest first
  readout_t pending_reads [$];

  // idling knobs, changed per phase by the stimulus process
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off: the stimulus bumps hold_asks, the receiver counts it down
  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;

  // bookkeeping for the run summary
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned sorts_done = 0;
  int unsigned largest_set = 0;
  int unsigned cycle_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // one sift from slot top down to slot bound; returns the operations it takes
  function automatic longint unsigned sift_down_ops(input int unsigned top,
                                                    input int unsigned bound);
    logic signed [VALUE_W-1:0] held;
    int unsigned               pos;
    int unsigned               child;
    longint unsigned           ops;
    bit                        settled;
    held = shadow_mem[top];
    pos = top;
    ops = 2;
    settled = 1'b0;
    while (!settled) begin
      child = 2 * pos;
      if (child > bound) begin
        settled = 1'b1;
      end else begin
        ops++;
        // slot 0 is its own first child, so only slot 1 can win there
        if (child < bound && shadow_mem[child + 1] < shadow_mem[child]) child++;
        ops++;
        if (shadow_mem[child] < held) begin
          ops++;
          shadow_mem[pos] = shadow_mem[child];
          pos = child;
        end else begin
          settled = 1'b1;
        end
      end
    end
    shadow_mem[pos] = held;
    return ops;
  endfunction

  // min-heap build then extraction, leaving the set in descending order
  function automatic void sort_descending();
    int unsigned               n;
    int unsigned               top;
    int unsigned               bound;
    longint unsigned           total;
    logic signed [VALUE_W-1:0] swap;
    n = shadow_count;
    total = 0;
    if (n == 0) begin
      total = 2;
    end else begin
      top = n / 2;
      total += sift_down_ops(top, n - 1);
      while (top != 0) begin
        top--;
        total += sift_down_ops(top, n - 1);
      end
      for (bound = n - 1; bound >= 1; bound--) begin
        swap = shadow_mem[0];
        shadow_mem[0] = shadow_mem[bound];
        shadow_mem[bound] = swap;
        total += 3;
        total += sift_down_ops(0, bound - 1);
      end
    end
    // the count saturates rather than wrapping
    shadow_ops = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
    shadow_sorted = 1'b1;
    sorts_done++;
    if (n > largest_set) largest_set = n;
  endfunction

  // applies one accepted item to the shadow; returns 1 with the result for a read
  function automatic bit apply_item(input logic c, input logic signed [VALUE_W-1:0] v,
                                    input logic l, input logic [INDEX_W-1:0] ix,
                                    output readout_t want);
    want = NO_WANT;
    if (c == CMD_LOAD) begin
      // first load after a sort opens a new set
      if (shadow_sorted) begin
        shadow_count = 0;
        shadow_sorted = 1'b0;
      end
      // a full store drops the value, but last still starts the sort
      if (shadow_count < MAX_ELEMENTS) begin
        shadow_mem[shadow_count] = v;
        shadow_count++;
      end
      if (l) sort_descending();
      return 1'b0;
    end
    want.value = (ix < shadow_count) ? shadow_mem[ix] : '0;
    want.ops = shadow_ops;
    return 1'b1;
  endfunction

  // value mix: full random, a narrow band that makes duplicates, and the extremes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(8) - 4;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // mostly inside the loaded set, sometimes anywhere in the index range
  function automatic logic [INDEX_W-1:0] pick_index();
    if (shadow_count == 0 || $urandom_range(3) == 0) return INDEX_W'($urandom_range(1023));
    return INDEX_W'($urandom_range(shadow_count - 1));
  endfunction

  // offers one item, waits for the handshake and records what it should produce;
  // entered and left at a rising edge, valid stays high unless the next call idles
  task automatic push_item(input logic c, input logic signed [VALUE_W-1:0] v, input logic l,
                           input logic [INDEX_W-1:0] ix, input bit typed = 1'b0,
                           input readout_t typed_want = NO_WANT);
    readout_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      // idle cycle with junk on the payload
      in_valid <= 1'b0;
      cmd <= 1'($urandom_range(1));
      value <= $urandom;
      last <= 1'($urandom_range(1));
      index <= INDEX_W'($urandom_range(1023));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    value <= v;
    last <= l;
    index <= ix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (apply_item(c, v, l, ix, want)) pending_reads.push_back(typed ? typed_want : want);
  endtask

  // sender pause until every read result has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // one well-formed set with random content, a few reads mixed into the loads
  // (reads before the sort) and a burst of reads afterwards
  task automatic run_random_set();
    int unsigned set_size;
    int unsigned i;
    set_size = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    for (i = 0; i < set_size; i++) begin
      if ($urandom_range(9) == 0)
        push_item(CMD_READ, $urandom, 1'($urandom_range(1)), pick_index());
      push_item(CMD_LOAD, pick_value(), i == set_size - 1, INDEX_W'($urandom_range(1023)));
    end
    repeat ($urandom_range(2, 10))
      push_item(CMD_READ, $urandom, 1'($urandom_range(1)), pick_index());
  endtask

  // receiver: random stall per cycle, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: every accepted result against the oldest pending read
  always @(posedge clk) begin
    readout_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_reads.size() == 0) begin
        report_mismatch("result with no read pending", sorted_value, 0);
      end else begin
        want = pending_reads.pop_front();
        if (sorted_value !== want.value)
          report_mismatch("sorted_value", sorted_value, want.value);
        if (op_count !== want.ops)
          report_mismatch("op_count", op_count, want.ops);
      end
    end
  end

  // watchdog, sized well above the slowest legal run including the full-store sort
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("timeout after %0d cycles, %0d reads still pending", cycle_count,
             pending_reads.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned phase_goal;
    int unsigned i;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    for (i = 0; i < DIRECTED_ROWS; i++)
      push_item(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].index,
                DIRECTED[i].typed, DIRECTED[i].want);
    wait_for_drain();

    // random phases: no idling, sender idle, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_gap_pct = 31;
          recv_stall_pct = 31;
        end
      endcase

      if (phase == 0) begin
        // fill the store to the top, then two more loads that are dropped;
        // the second carries last and still starts the sort of all entries
        for (i = 0; i < MAX_ELEMENTS; i++)
          push_item(CMD_LOAD, pick_value(), 1'b0, INDEX_W'($urandom_range(1023)));
        push_item(CMD_LOAD, pick_value(), 1'b0, INDEX_W'($urandom_range(1023)));
        push_item(CMD_LOAD, pick_value(), 1'b1, INDEX_W'($urandom_range(1023)));
        // first read waits out the sort, then the receiver holds off while
        // reads keep coming, so the result register fills and the input stalls
        push_item(CMD_READ, $urandom, 1'($urandom_range(1)), '0);
        hold_asks++;
        push_item(CMD_READ, $urandom, 1'($urandom_range(1)), '1);
        repeat (40) push_item(CMD_READ, $urandom, 1'($urandom_range(1)), pick_index());
        wait_for_drain();
      end

      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) run_random_set();
      wait_for_drain();
    end

    // last item is always a read; let its result settle before the summary
    repeat (20) @(posedge clk);

    $display("run covered %0d items, %0d results, %0d sorts (largest set %0d, full store)",
             items_sent, results_seen, sorts_done, largest_set);
    $display("idling: none, sender 65%%, receiver 65%%, both 31%%, plus a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
